/* rtl/bcd_rtc_register_file_core_assert.svh */
// ----------------------------------------------------------------------------
// bcd rtc register file assertion macros
// Concurrent assertion wrappers shared by the rtc register file modules.
// ----------------------------------------------------------------------------
`ifndef BCD_RTC_REGISTER_FILE_CORE_ASSERT_SVH
`define BCD_RTC_REGISTER_FILE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BRTC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRTC_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRTC_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

/* rtl/brtc_pkg.sv */
// ----------------------------------------------------------------------------
// brtc_pkg
// Types, register map, command codes and counter helpers for the rtc core.
// ----------------------------------------------------------------------------
package brtc_pkg;

	typedef logic [3:0] nib_t;
	typedef logic [3:0] addr_t;
	typedef nib_t [15:0] brtc_file_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam addr_t IX_TEST   = 4'd0;
	localparam addr_t IX_TENTHS = 4'd1;
	localparam addr_t IX_SEC1   = 4'd2;
	localparam addr_t IX_SEC10  = 4'd3;
	localparam addr_t IX_MIN1   = 4'd4;
	localparam addr_t IX_MIN10  = 4'd5;
	localparam addr_t IX_HOUR1  = 4'd6;
	localparam addr_t IX_HOUR10 = 4'd7;
	localparam addr_t IX_DAY1   = 4'd8;
	localparam addr_t IX_DAY10  = 4'd9;
	localparam addr_t IX_WDAY   = 4'd10;
	localparam addr_t IX_MON1   = 4'd11;
	localparam addr_t IX_MON10  = 4'd12;
	localparam addr_t IX_YEAR   = 4'd13;
	localparam addr_t IX_RESET  = 4'd14;
	localparam addr_t IX_INTR   = 4'd15;

	// weekday, day units and month units come up as one
	localparam brtc_file_t FILE_RESET = 64'h0000_1101_0000_0000;

	localparam logic [7:0] RD_NONE    = 8'hFF;
	localparam logic [7:0] SEC_SPAN   = 8'd60;
	localparam logic [7:0] HOUR_SPAN  = 8'd24;
	localparam logic [7:0] MONTH_SPAN = 8'd12;

	typedef struct packed {
		logic  tick;
		logic  wr;
		addr_t addr;
		nib_t  wdata;
	} brtc_op_t;

	typedef struct packed {
		logic carry;
		nib_t hi;
		nib_t lo;
	} pair_t;

	function automatic logic [7:0] pair_value(nib_t lo_n, nib_t hi_n);
		return {1'b0, hi_n, 3'b000} + {3'b000, hi_n, 1'b0} + {4'h0, lo_n};
	endfunction

	// bump a units/tens pair, roll to lo_min at or past limit
	function automatic pair_t bump_pair(nib_t lo_n, nib_t hi_n, nib_t lo_min,
		logic [7:0] limit);
		logic [7:0] v;
		logic [7:0] rem;
		nib_t       q;
		pair_t      r;
		v = pair_value(lo_n, hi_n) + 8'd1;
		if (v >= 8'd50)      q = 4'd5;
		else if (v >= 8'd40) q = 4'd4;
		else if (v >= 8'd30) q = 4'd3;
		else if (v >= 8'd20) q = 4'd2;
		else if (v >= 8'd10) q = 4'd1;
		else                 q = 4'd0;
		rem = v - ({1'b0, q, 3'b000} + {3'b000, q, 1'b0});
		if (v >= limit) begin
			r.carry = 1'b1;
			r.hi    = 4'd0;
			r.lo    = lo_min;
		end else begin
			r.carry = 1'b0;
			r.hi    = q;
			r.lo    = rem[3:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] days_in_month(nib_t mon1, nib_t mon10, nib_t year);
		logic [7:0] m;
		logic [7:0] d;
		m = pair_value(mon1, mon10);
		if (m < 8'd1 || m > MONTH_SPAN) begin
			d = 8'd31;
		end else begin
			case (m[3:0])
				4'd2:    d = (year[1:0] == 2'b11) ? 8'd29 : 8'd28;
				4'd4:    d = 8'd30;
				4'd6:    d = 8'd30;
				4'd9:    d = 8'd30;
				4'd11:   d = 8'd30;
				default: d = 8'd31;
			endcase
		end
		return d;
	endfunction

endpackage

/* rtl/brtc_advance.sv */
// ----------------------------------------------------------------------------
// brtc_advance
// Next-second logic: cascaded bcd counters from seconds up to the year.
// ----------------------------------------------------------------------------
module brtc_advance (
	input  brtc_pkg::brtc_file_t cur,
	output brtc_pkg::brtc_file_t nxt
);
	import brtc_pkg::*;

	pair_t      sec;
	pair_t      mins;
	pair_t      hrs;
	pair_t      day;
	pair_t      mon;
	logic [7:0] dim;

	always_comb begin
		nxt  = cur;
		sec  = bump_pair(cur[IX_SEC1], cur[IX_SEC10], 4'd0, SEC_SPAN);
		mins = bump_pair(cur[IX_MIN1], cur[IX_MIN10], 4'd0, SEC_SPAN);
		hrs  = bump_pair(cur[IX_HOUR1], cur[IX_HOUR10], 4'd0, HOUR_SPAN);
		dim  = days_in_month(cur[IX_MON1], cur[IX_MON10], cur[IX_YEAR]);
		day  = bump_pair(cur[IX_DAY1], cur[IX_DAY10], 4'd1, dim + 8'd1);
		mon  = bump_pair(cur[IX_MON1], cur[IX_MON10], 4'd1, MONTH_SPAN + 8'd1);
		if (cur[IX_RESET][0]) begin
			nxt[IX_SEC1]  = sec.lo;
			nxt[IX_SEC10] = sec.hi;
			if (sec.carry) begin
				nxt[IX_MIN1]  = mins.lo;
				nxt[IX_MIN10] = mins.hi;
				if (mins.carry) begin
					nxt[IX_HOUR1]  = hrs.lo;
					nxt[IX_HOUR10] = hrs.hi;
					if (hrs.carry) begin
						nxt[IX_DAY1]  = day.lo;
						nxt[IX_DAY10] = day.hi;
						if (day.carry) begin
							nxt[IX_MON1]  = mon.lo;
							nxt[IX_MON10] = mon.hi;
							if (mon.carry) begin
								nxt[IX_YEAR] = cur[IX_YEAR] + 4'd1;
							end
						end
					end
				end
			end
		end
	end

endmodule

/* rtl/brtc_regfile.sv */
// ----------------------------------------------------------------------------
// brtc_regfile
// Sixteen nibble registers with tick update, host write and read decode.
// ----------------------------------------------------------------------------
`include "bcd_rtc_register_file_core_assert.svh"

module brtc_regfile (
	input  logic               clk,
	input  logic               arst_n,
	input  brtc_pkg::brtc_op_t op,
	output logic [7:0]         rd_data
);
	import brtc_pkg::*;

	brtc_file_t file_q;
	brtc_file_t tick_file;

	brtc_advance u_advance (
		.cur (file_q),
		.nxt (tick_file)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_q <= FILE_RESET;
		end else if (op.tick) begin
			file_q <= tick_file;
		end else if (op.wr && op.addr >= IX_MIN1) begin
			file_q[op.addr] <= op.wdata;
		end
	end

	always_comb begin
		if ((op.addr != IX_TEST && op.addr <= IX_MON10) || op.addr == IX_INTR) begin
			rd_data = {4'h0, file_q[op.addr]};
		end else begin
			rd_data = RD_NONE;
		end
	end

	`BRTC_ASSERT(a_sec_bcd, clk, arst_n,
		(file_q[IX_SEC1] <= 4'd9 && file_q[IX_SEC10] <= 4'd5),
		"seconds left valid bcd range")
	`BRTC_ASSERT(a_fixed_zero, clk, arst_n,
		(file_q[IX_TEST] == 4'd0 && file_q[IX_TENTHS] == 4'd0),
		"test or tenths register changed")
	`BRTC_ASSERT(a_halted_tick, clk, arst_n,
		(op.tick && !file_q[IX_RESET][0]) |=> $stable(file_q),
		"tick changed state while clock halted")

endmodule

/* rtl/bcd_rtc_register_file_core.sv */
// ----------------------------------------------------------------------------
// bcd_rtc_register_file_core
// Bcd real-time clock held in sixteen nibble registers, stream interface.
// ----------------------------------------------------------------------------
// Each input word on s_axis is a one-second tick, a register write or a
// register read (a fourth code does nothing). Ticks advance seconds through
// year only while bit 0 of the reset register is set. Writes and ticks give
// no output word; each read gives one word on m_axis: the nibble for
// registers 1 to 12 and 15, 0xFF for the rest.
// An input word is registered and executed from the input register against
// the register file, where a read waits while the result register is full;
// a read result is registered again before it appears on m_axis.
// One word is taken every cycle while no read waits; the counter cascade
// and read decode sit in a single stage between input and output registers.
// When m_axis stalls, the pending read result holds; ticks and writes keep
// flowing until a following read reaches the input register, and
// s_axis_tready drops only while that read is held there.
// Reset (arst_n low) empties both registers and loads the clock with day 1,
// month 1, weekday 1, everything else zero and the clock halted.
// ----------------------------------------------------------------------------
`include "bcd_rtc_register_file_core_assert.svh"

module bcd_rtc_register_file_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cmd[1:0], reg_addr[5:2], write_data[9:6]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // read_data[7:0]
);
	import brtc_pkg::*;

	logic       valid_s1;
	cmd_t       cmd_s1;
	addr_t      addr_s1;
	nib_t       wdata_s1;
	logic       valid_s2;
	logic [7:0] read_data_s2;

	logic       is_rd;
	logic       out_free;
	logic       fire;
	brtc_op_t   op;
	logic [7:0] rd_data;

	assign is_rd         = (cmd_s1 == CMD_READ);
	assign out_free      = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && (!is_rd || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	assign op.tick  = fire && (cmd_s1 == CMD_TICK);
	assign op.wr    = fire && (cmd_s1 == CMD_WRITE);
	assign op.addr  = addr_s1;
	assign op.wdata = wdata_s1;

	brtc_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.rd_data (rd_data)
	);

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1   <= cmd_t'(s_axis_tdata[1:0]);
			addr_s1  <= s_axis_tdata[5:2];
			wdata_s1 <= s_axis_tdata[9:6];
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && is_rd) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_rd) begin
			read_data_s2 <= rd_data;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = read_data_s2;

	`BRTC_ASSERT(a_read_lands, clk, arst_n,
		(fire && is_rd) |=> (m_axis_tvalid && m_axis_tdata == $past(rd_data)),
		"read result not captured")
	`BRTC_ASSERT(a_result_form, clk, arst_n,
		m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'h0 || m_axis_tdata == RD_NONE),
		"read result neither nibble nor 0xFF")

endmodule

/* tb/sv/bcd_rtc_register_file_core_tb.sv */
// ----------------------------------------------------------------------------
// bcd_rtc_register_file_core_tb
// Self-checking bench for the bcd rtc register file core.
// ----------------------------------------------------------------------------
// Ticks, register writes, register reads and idle codes are sent on the
// input stream with random gaps, and read words are taken on the output
// stream with random stalls. A scoreboard keeps its own copy of the sixteen
// nibble registers, advances the seconds-to-year cascade on every tick and
// queues the word each read should return. Every output word is checked in
// order against that queue. A short directed opening covers reset values,
// ignored writes, the idle code and the halted clock. The random part then
// loads dates close to minute, hour, day, month and year rollover, with leap
// and out-of-range months and counters, runs bursts of ticks across them,
// and mixes in raw noise and full read sweeps.
// ----------------------------------------------------------------------------
module bcd_rtc_register_file_core_tb;

	import brtc_pkg::*;

	localparam int IDLE_LIMIT  = 1000;
	localparam int STIM_ITEMS  = 925;
	localparam int DRAIN_TICKS = 8;

	class rtc_scoreboard;
		nib_t       clock_regs[16];
		logic [7:0] reads_due[$];
		int         errors;

		function new();
			for (int i = 0; i < 16; i++) clock_regs[i] = 4'd0;
			clock_regs[IX_WDAY] = 4'd1;
			clock_regs[IX_DAY1] = 4'd1;
			clock_regs[IX_MON1] = 4'd1;
			errors = 0;
		endfunction

		function int month_days(nib_t m1, nib_t m10, nib_t yr);
			int m;
			m = int'(m10) * 10 + int'(m1);
			if (m < 1 || m > 12) return 31;
			case (m)
				2: return (yr[1:0] == 2'b11) ? 29 : 28;
				4, 6, 9, 11: return 30;
				default: return 31;
			endcase
		endfunction

		// true when the pair rolls over and carries
		function bit step_pair(int lo_ix, int lo_min, int span);
			int v;
			v = int'(clock_regs[lo_ix + 1]) * 10 + int'(clock_regs[lo_ix]) + 1;
			if (v >= span + lo_min) begin
				clock_regs[lo_ix]     = nib_t'(lo_min);
				clock_regs[lo_ix + 1] = 4'd0;
				return 1'b1;
			end
			clock_regs[lo_ix]     = nib_t'(v % 10);
			clock_regs[lo_ix + 1] = nib_t'(v / 10);
			return 1'b0;
		endfunction

		function void advance_second();
			int d;
			if (!clock_regs[IX_RESET][0]) return;
			if (!step_pair(IX_SEC1, 0, 60)) return;
			if (!step_pair(IX_MIN1, 0, 60)) return;
			if (!step_pair(IX_HOUR1, 0, 24)) return;
			d = month_days(clock_regs[IX_MON1], clock_regs[IX_MON10], clock_regs[IX_YEAR]);
			if (!step_pair(IX_DAY1, 1, d)) return;
			if (!step_pair(IX_MON1, 1, 12)) return;
			clock_regs[IX_YEAR] = clock_regs[IX_YEAR] + 4'd1;
		endfunction

		function void note_input(cmd_t c, addr_t a, nib_t d);
			case (c)
				CMD_TICK: advance_second();
				CMD_WRITE: begin
					if (a >= IX_MIN1) clock_regs[a] = d;
				end
				CMD_READ: begin
					if ((a >= IX_TENTHS && a <= IX_MON10) || a == IX_INTR)
						reads_due.push_back({4'h0, clock_regs[a]});
					else
						reads_due.push_back(RD_NONE);
				end
				default: ;
			endcase
		endfunction

		function void check_read(logic [7:0] got);
			logic [7:0] want;
			if (reads_due.size() == 0) begin
				$error("read_data: expected none, actual 0x%02h", got);
				errors++;
				return;
			end
			want = reads_due.pop_front();
			if (got !== want) begin
				$error("read_data: expected 0x%02h, actual 0x%02h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return reads_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'h0000;  // cmd[1:0], reg_addr[5:2], write_data[9:6]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;             // read_data[7:0]

	rtc_scoreboard sb;
	int            items_sent = 0;
	int            send_calm = 0;
	int            recv_calm = 0;
	int            idle_cycles = 0;

	bcd_rtc_register_file_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap before the next word, with runs of back-to-back words
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 50);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	task automatic send_word(cmd_t c, addr_t a, nib_t d);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b000000, d, a, c};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(c, a, d);
		items_sent++;
	endtask

	task automatic write_reg(addr_t a, nib_t d);
		send_word(CMD_WRITE, a, d);
	endtask

	task automatic read_reg(addr_t a);
		send_word(CMD_READ, a, nib_t'($urandom_range(0, 15)));
	endtask

	task automatic tick_once();
		send_word(CMD_TICK, addr_t'($urandom_range(0, 15)), nib_t'($urandom_range(0, 15)));
	endtask

	// load a date near rollover, run a burst of ticks with reads mixed in, then read registers 2 to 13
	task automatic run_rollover();
		int   mon;
		int   dd;
		int   n;
		nib_t m1;
		nib_t m10;
		nib_t yr;
		if ($urandom_range(0, 7) == 0)
			write_reg(IX_RESET, nib_t'({$urandom_range(0, 7), 1'b0}));
		else
			write_reg(IX_RESET, nib_t'({$urandom_range(0, 7), 1'b1}));
		if ($urandom_range(0, 3) != 0) begin
			write_reg(IX_MIN1, 4'd9);
			write_reg(IX_MIN10, 4'd5);
		end else begin
			write_reg(IX_MIN1, nib_t'($urandom_range(0, 15)));
			write_reg(IX_MIN10, nib_t'($urandom_range(0, 15)));
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(IX_HOUR1, 4'd3);
			write_reg(IX_HOUR10, 4'd2);
		end else begin
			write_reg(IX_HOUR1, nib_t'($urandom_range(0, 15)));
			write_reg(IX_HOUR10, nib_t'($urandom_range(0, 15)));
		end
		case ($urandom_range(0, 9))
			0, 1: mon = 12;
			2, 3: mon = 2;
			4, 5, 6: mon = $urandom_range(1, 12);
			default: mon = -1;
		endcase
		if (mon < 0) begin
			m1  = nib_t'($urandom_range(0, 15));
			m10 = nib_t'($urandom_range(0, 15));
		end else begin
			m1  = nib_t'(mon % 10);
			m10 = nib_t'(mon / 10);
		end
		if ($urandom_range(0, 2) == 0) yr = 4'd15;
		else if ($urandom_range(0, 1) == 0) yr = nib_t'({$urandom_range(0, 3), 2'b11});
		else yr = nib_t'($urandom_range(0, 15));
		if ($urandom_range(0, 3) != 0) dd = sb.month_days(m1, m10, yr);
		else dd = $urandom_range(0, 31);
		if ($urandom_range(0, 7) == 0) begin
			write_reg(IX_DAY1, nib_t'($urandom_range(0, 15)));
			write_reg(IX_DAY10, nib_t'($urandom_range(0, 15)));
		end else begin
			write_reg(IX_DAY1, nib_t'(dd % 10));
			write_reg(IX_DAY10, nib_t'(dd / 10));
		end
		write_reg(IX_MON1, m1);
		write_reg(IX_MON10, m10);
		write_reg(IX_YEAR, yr);
		n = $urandom_range(1, 75);
		repeat (n) begin
			tick_once();
			if ($urandom_range(0, 5) == 0) read_reg(addr_t'($urandom_range(0, 15)));
		end
		for (int i = 2; i <= 13; i++) read_reg(addr_t'(i));
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, including the unreadable registers
		send_word(CMD_READ, IX_TEST, 4'h0);
		send_word(CMD_READ, IX_TENTHS, 4'hF);
		send_word(CMD_READ, IX_DAY1, 4'h0);
		send_word(CMD_READ, IX_WDAY, 4'hF);
		send_word(CMD_READ, IX_MON1, 4'h0);
		send_word(CMD_READ, IX_YEAR, 4'hF);
		send_word(CMD_READ, IX_RESET, 4'h0);
		send_word(CMD_READ, IX_INTR, 4'hF);
		// writes to the low registers are dropped
		write_reg(IX_TEST, 4'hF);
		write_reg(IX_SEC10, 4'hF);
		send_word(CMD_READ, IX_SEC10, 4'h0);
		send_word(CMD_NOP, 4'hF, 4'hF);
		// halted clock ignores ticks, a running clock advances
		send_word(CMD_TICK, 4'hF, 4'hF);
		send_word(CMD_READ, IX_SEC1, 4'h0);
		write_reg(IX_RESET, 4'hF);
		send_word(CMD_TICK, 4'h0, 4'h0);
		send_word(CMD_READ, IX_SEC1, 4'h0);
		// out-of-range counter and month, and the interrupt register
		write_reg(IX_MIN10, 4'hF);
		write_reg(IX_MON10, 4'h1);
		write_reg(IX_MON1, 4'h5);
		write_reg(IX_INTR, 4'h0);
		send_word(CMD_READ, IX_INTR, 4'hF);
		send_word(CMD_READ, IX_MIN10, 4'h0);

		while (items_sent < STIM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: run_rollover();
				6, 7: begin
					repeat ($urandom_range(10, 30))
						send_word(cmd_t'($urandom_range(0, 3)), addr_t'($urandom_range(0, 15)),
							nib_t'($urandom_range(0, 15)));
				end
				default: begin
					for (int i = 0; i < 16; i++) read_reg(addr_t'(i));
				end
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		int gap;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_read(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

/* files.f */
+incdir+rtl
rtl/brtc_pkg.sv
rtl/brtc_advance.sv
rtl/brtc_regfile.sv
rtl/bcd_rtc_register_file_core.sv
tb/sv/bcd_rtc_register_file_core_tb.sv
